// ===== rtl/cluster_purity_metric_top_assert.svh =====
// assertion macros used by the top-level rtl file
`ifndef CLUSTER_PURITY_METRIC_TOP_ASSERT_SVH
`define CLUSTER_PURITY_METRIC_TOP_ASSERT_SVH

// same-cycle implication, checked out of reset
`define CPM_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define CPM_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/cpm_pkg.sv =====
package cpm_pkg;

    // field widths
    localparam int LBL_W       = 8;
    localparam int CFG_W       = 5;
    localparam int LIM_W       = 9;
    localparam int OUT_CNT_W   = 16;
    localparam int PUR_W       = 17;
    localparam int DIV_CNT_W   = 5;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 56;
    localparam int CFG_IDX_W   = 1;

    // register reset value
    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NUM_CLUSTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_NUM_CLASSES  = 1'b1;

    // sequencer states
    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_INCR  = 5'b00100,
        ST_SCAN  = 5'b01000,
        ST_DIV   = 5'b10000
    } cpm_state_t;

endpackage

// ===== rtl/cpm_count_mem.sv =====
module cpm_count_mem #(
    parameter int ADDR_W = 8,
    parameter int DATA_W = 16
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    localparam int DEPTH = 1 << ADDR_W;

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    // one write port, one registered read port, read-first
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/cpm_sub_unit.sv =====
module cpm_sub_unit #(
    parameter int W = 17
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);

    logic [W:0] full;

    // subtract with borrow out; no borrow means a >= b
    assign full = {1'b0, a} - {1'b0, b};
    assign diff = full[W-1:0];
    assign ge   = ~full[W];

endmodule

// ===== rtl/cluster_purity_metric_top.sv =====
// Flow: an item that is not counted in the table needs only its transfer in IDLE; a counted one
// also passes through INCR (table read, then write back). A last item then starts a scan over
// the whole count memory and the bit-serial divider before the result shows on m_*.
// Input: s_tready is low while a count is written back and while a set is scanned and divided.
// Reset: asynchronous, active low; afterwards a clearing pass over all 2^ADDR_W entries (256 at
// default) zeroes the count memory while s_tready stays low.
`include "cluster_purity_metric_top_assert.svh"

module cluster_purity_metric_top #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_CLASSES  = 16,
    parameter int COUNT_BITS   = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave stream, tdata: cluster_label[7:0], class_label[15:8]
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [cpm_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic                                s_tlast,
    // master stream, tdata: purity[16:0], max_sum[32:17], total_items[48:33], zero pad
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [cpm_pkg::OUT_TDATA_W-1:0]     m_tdata,
    // tuser: label_error[0]
    output logic                                m_tuser,
    // configuration write port
    input  logic                                cfg_we,
    input  logic [cpm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpm_pkg::CFG_W-1:0]           cfg_data
);

    localparam int CLU_W  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CLS_W  = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int ADDR_W = CLU_W + CLS_W;
    localparam int CB     = COUNT_BITS;
    localparam logic [cpm_pkg::LIM_W-1:0] LIM_CLU = cpm_pkg::LIM_W'(MAX_CLUSTERS);
    localparam logic [cpm_pkg::LIM_W-1:0] LIM_CLS = cpm_pkg::LIM_W'(MAX_CLASSES);

    cpm_pkg::cpm_state_t state_reg, state_next;

    logic [ADDR_W:0]                  cnt_reg, cnt_next;
    logic [ADDR_W-1:0]                p_addr_reg;
    logic [ADDR_W-1:0]                upd_addr_reg, upd_addr_next;
    logic                             last_reg, last_next;
    logic [CB-1:0]                    total_reg, total_next;
    logic                             err_reg, err_next;
    logic [CB-1:0]                    best_reg, best_next;
    logic [CB-1:0]                    sum_reg, sum_next;
    logic [CB-1:0]                    rem_reg, rem_next;
    logic [cpm_pkg::PUR_W-1:0]        quo_reg, quo_next;
    logic [cpm_pkg::DIV_CNT_W-1:0]    div_cnt_reg, div_cnt_next;
    logic [cpm_pkg::CFG_W-1:0]        n_clu_reg, n_cls_reg;
    logic                             out_valid_reg, out_valid_next;
    logic [cpm_pkg::OUT_TDATA_W-1:0]  out_data_reg, out_data_next;
    logic                             out_err_reg, out_err_next;

    // clamped register values
    logic [cpm_pkg::LIM_W-1:0] n_clu_eff, n_cls_eff;
    assign n_clu_eff = ({4'b0, n_clu_reg} > LIM_CLU) ? LIM_CLU : {4'b0, n_clu_reg};
    assign n_cls_eff = ({4'b0, n_cls_reg} > LIM_CLS) ? LIM_CLS : {4'b0, n_cls_reg};

    // input fields and the decision for one item
    logic [cpm_pkg::LBL_W-1:0] in_clu, in_cls;
    logic                      accept, at_limit, clu_used, cls_ok;
    assign in_clu   = s_tdata[cpm_pkg::LBL_W-1:0];
    assign in_cls   = s_tdata[2*cpm_pkg::LBL_W-1:cpm_pkg::LBL_W];
    assign s_tready = (state_reg == cpm_pkg::ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign at_limit = (total_reg == {CB{1'b1}});
    assign clu_used = ({1'b0, in_clu} < n_clu_eff);
    assign cls_ok   = ({1'b0, in_cls} < n_cls_eff);

    // count memory
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [CB-1:0]     mem_wdata, mem_rdata;

    cpm_count_mem #(
        .ADDR_W(ADDR_W),
        .DATA_W(CB)
    ) u_mem (
        .clk  (clk),
        .we   (mem_we),
        .waddr(mem_waddr),
        .wdata(mem_wdata),
        .raddr(mem_raddr),
        .rdata(mem_rdata)
    );

    // shared compare/subtract unit: row max during scan, trial subtract during divide
    logic [CB:0] alu_a, alu_b, alu_diff;
    logic        alu_ge;
    logic [CB:0] trial;

    cpm_sub_unit #(
        .W(CB + 1)
    ) u_sub (
        .a   (alu_a),
        .b   (alu_b),
        .diff(alu_diff),
        .ge  (alu_ge)
    );

    assign trial = (div_cnt_reg == '0) ? {1'b0, rem_reg} : {rem_reg, 1'b0};

    always_comb
    begin
        if (state_reg == cpm_pkg::ST_DIV)
        begin
            alu_a = trial;
            alu_b = {1'b0, total_reg};
        end
        else
        begin
            alu_a = {1'b0, mem_rdata};
            alu_b = {1'b0, best_reg};
        end
    end

    // scan stage: entry under test and its place in the table
    logic [CLU_W-1:0] p_clu;
    logic [CLS_W-1:0] p_cls;
    logic             p_used, p_row_end;
    logic [CB-1:0]    p_best;
    assign p_clu     = p_addr_reg[ADDR_W-1:CLS_W];
    assign p_cls     = p_addr_reg[CLS_W-1:0];
    assign p_used    = (cpm_pkg::LIM_W'(p_clu) < n_clu_eff) &&
                       (cpm_pkg::LIM_W'(p_cls) < n_cls_eff);
    assign p_row_end = (p_cls == {CLS_W{1'b1}});
    assign p_best    = (p_used && alu_ge) ? mem_rdata : best_reg;

    // result fields widened to 32 bits
    logic [31:0] sum_ext, total_ext;
    logic [cpm_pkg::PUR_W-1:0] purity_val;
    assign sum_ext    = 32'(sum_reg);
    assign total_ext  = 32'(total_reg);
    assign purity_val = (total_reg == '0) ? '0 : quo_reg;

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        upd_addr_next  = upd_addr_reg;
        last_next      = last_reg;
        total_next     = total_reg;
        err_next       = err_reg;
        best_next      = best_reg;
        sum_next       = sum_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_cnt_next   = div_cnt_reg;
        out_data_next  = out_data_reg;
        out_err_next   = out_err_reg;
        out_valid_next = m_tready ? 1'b0 : out_valid_reg;
        mem_we         = 1'b0;
        mem_waddr      = cnt_reg[ADDR_W-1:0];
        mem_wdata      = '0;
        mem_raddr      = cnt_reg[ADDR_W-1:0];

        case (state_reg)
            cpm_pkg::ST_CLEAR:
            begin
                // zero the count memory one entry a cycle
                mem_we   = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg[ADDR_W-1:0] == {ADDR_W{1'b1}})
                begin
                    cnt_next   = '0;
                    state_next = cpm_pkg::ST_IDLE;
                end
            end
            cpm_pkg::ST_IDLE:
            begin
                mem_raddr = {in_clu[CLU_W-1:0], in_cls[CLS_W-1:0]};
                if (accept)
                begin
                    last_next     = s_tlast;
                    upd_addr_next = mem_raddr;
                    cnt_next      = '0;
                    best_next     = '0;
                    sum_next      = '0;
                    if (at_limit)
                    begin
                        err_next = 1'b1;
                    end
                    else if (clu_used && !cls_ok)
                    begin
                        err_next = 1'b1;
                    end
                    else
                    begin
                        total_next = total_reg + 1'b1;
                    end
                    if (!at_limit && clu_used && cls_ok)
                    begin
                        state_next = cpm_pkg::ST_INCR;
                    end
                    else if (s_tlast)
                    begin
                        state_next = cpm_pkg::ST_SCAN;
                    end
                end
            end
            cpm_pkg::ST_INCR:
            begin
                // write back the incremented count
                mem_we     = 1'b1;
                mem_waddr  = upd_addr_reg;
                mem_wdata  = mem_rdata + CB'(1);
                state_next = last_reg ? cpm_pkg::ST_SCAN : cpm_pkg::ST_IDLE;
            end
            cpm_pkg::ST_SCAN:
            begin
                // issue read and clear of one entry, test the entry read in the previous cycle
                mem_we   = ~cnt_reg[ADDR_W];
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg != '0)
                begin
                    if (p_row_end)
                    begin
                        sum_next  = sum_reg + p_best;
                        best_next = '0;
                    end
                    else
                    begin
                        best_next = p_best;
                    end
                end
                if (cnt_reg[ADDR_W])
                begin
                    rem_next     = sum_next;
                    quo_next     = '0;
                    div_cnt_next = '0;
                    state_next   = cpm_pkg::ST_DIV;
                end
            end
            cpm_pkg::ST_DIV:
            begin
                // restoring divide, one quotient bit a cycle
                if (div_cnt_reg < cpm_pkg::DIV_CNT_W'(cpm_pkg::PUR_W))
                begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                    if (alu_ge)
                    begin
                        rem_next = alu_diff[CB-1:0];
                        quo_next = {quo_reg[cpm_pkg::PUR_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = trial[CB-1:0];
                        quo_next = {quo_reg[cpm_pkg::PUR_W-2:0], 1'b0};
                    end
                end
                else if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {7'b0, total_ext[cpm_pkg::OUT_CNT_W-1:0],
                                      sum_ext[cpm_pkg::OUT_CNT_W-1:0], purity_val};
                    out_err_next   = err_reg;
                    total_next     = '0;
                    err_next       = 1'b0;
                    state_next     = cpm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cpm_pkg::ST_CLEAR;
                cnt_next   = '0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cpm_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            total_reg     <= '0;
            err_reg       <= 1'b0;
            last_reg      <= 1'b0;
            div_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
            n_clu_reg     <= cpm_pkg::CFG_RESET;
            n_cls_reg     <= cpm_pkg::CFG_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            err_reg       <= err_next;
            last_reg      <= last_next;
            div_cnt_reg   <= div_cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we && cfg_index == cpm_pkg::CFG_IDX_NUM_CLUSTERS)
            begin
                n_clu_reg <= cfg_data;
            end
            if (cfg_we && cfg_index == cpm_pkg::CFG_IDX_NUM_CLASSES)
            begin
                n_cls_reg <= cfg_data;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        p_addr_reg   <= cnt_reg[ADDR_W-1:0];
        upd_addr_reg <= upd_addr_next;
        best_reg     <= best_next;
        sum_reg      <= sum_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        out_data_reg <= out_data_next;
        out_err_reg  <= out_err_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // checks
    `CPM_ASSERT_IMP(a_purity_range, clk, rst_n, m_tvalid, m_tdata[16:0] <= 17'd65536, "purity above one")
    `CPM_ASSERT_IMP(a_sum_le_total, clk, rst_n, state_reg == cpm_pkg::ST_DIV, sum_reg <= total_reg, "max sum above total")
    `CPM_ASSERT_NXT(a_last_blocks, clk, rst_n, accept && s_tlast, !s_tready, "input taken after last transfer")
    `CPM_ASSERT_IMP(a_scan_clears, clk, rst_n, state_reg == cpm_pkg::ST_SCAN && mem_we, mem_wdata == '0, "scan writes nonzero count")

endmodule

// ===== tb/sv/cluster_purity_metric_top_tb.sv =====
`timescale 1ns / 1ps

module cluster_purity_metric_top_tb;

    localparam int     TB_MAX_CLUSTERS = 16;
    localparam int     TB_MAX_CLASSES  = 16;
    localparam int     COUNT_LIMIT     = 65535;
    localparam int     SETTLE_CYCLES   = 320;
    localparam int     PHASE_ITEMS     = 470;
    localparam int     HOLD_CYCLES     = 700;
    localparam longint CYCLE_LIMIT     = 5000000;

    // one purity result as it leaves the block
    typedef struct packed {
        logic [cpm_pkg::PUR_W-1:0]     purity;
        logic [cpm_pkg::OUT_CNT_W-1:0] max_sum;
        logic [cpm_pkg::OUT_CNT_W-1:0] total_items;
        logic                          label_error;
    } purity_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            s_tvalid;
    logic                            s_tready;
    logic [cpm_pkg::IN_TDATA_W-1:0]  s_tdata;
    logic                            s_tlast;
    logic                            m_tvalid;
    logic                            m_tready;
    logic [cpm_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            cfg_we;
    logic [cpm_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [cpm_pkg::CFG_W-1:0]       cfg_data;

    // shadow of the block: registers, count table, total and error flag
    logic [cpm_pkg::CFG_W-1:0]       shadow_clusters;
    logic [cpm_pkg::CFG_W-1:0]       shadow_classes;
    logic [15:0]            class_tally [TB_MAX_CLUSTERS][TB_MAX_CLASSES];
    logic [15:0]            set_total;
    logic                   set_error;

    purity_result_t         expected_purity [$];
    int                     mismatch_count;
    longint                 cycle_count;
    int                     sender_idle_pct;
    int                     sink_idle_pct;
    bit                     hold_request;

    cluster_purity_metric_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // clock, 2 ns period
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[cluster_purity_metric_top] ERROR");
            $finish;
        end
    end

    // effective register value after clamping
    function automatic int in_use(input logic [cpm_pkg::CFG_W-1:0] value, input int cap);
        return (int'(value) > cap) ? cap : int'(value);
    endfunction

    // count one sample, and on the last one form the set's purity
    function automatic void tally_sample(input logic [7:0] clu, input logic [7:0] cls,
                                         input logic is_last);
        int             n_clu;
        int             n_cls;
        int unsigned    best;
        int unsigned    max_sum;
        longint         scaled;
        purity_result_t res;
        n_clu = in_use(shadow_clusters, TB_MAX_CLUSTERS);
        n_cls = in_use(shadow_classes, TB_MAX_CLASSES);
        if (set_total == COUNT_LIMIT)
            set_error = 1'b1;
        else if (clu < n_clu)
        begin
            if (cls < n_cls)
            begin
                class_tally[clu[3:0]][cls[3:0]] = class_tally[clu[3:0]][cls[3:0]] + 1;
                set_total = set_total + 1;
            end
            else
                set_error = 1'b1;
        end
        else
            set_total = set_total + 1;
        if (!is_last)
            return;
        // largest class count per cluster in use
        max_sum = 0;
        for (int c = 0; c < n_clu; c++)
        begin
            best = 0;
            for (int k = 0; k < n_cls; k++)
                if (class_tally[c][k] > best)
                    best = class_tally[c][k];
            max_sum += best;
        end
        scaled = 0;
        if (set_total != 0)
            scaled = (longint'(max_sum) << 16) / longint'(set_total);
        res.purity      = scaled[cpm_pkg::PUR_W-1:0];
        res.max_sum     = max_sum[15:0];
        res.total_items = set_total;
        res.label_error = set_error;
        expected_purity.push_back(res);
        // set cleared after the result
        for (int c = 0; c < TB_MAX_CLUSTERS; c++)
            for (int k = 0; k < TB_MAX_CLASSES; k++)
                class_tally[c][k] = '0;
        set_total = '0;
        set_error = 1'b0;
    endfunction

    // offer one sample and wait for its transfer
    task automatic send_sample(input logic [7:0] clu, input logic [7:0] cls,
                               input logic is_last);
        int gap;
        if (int'($urandom_range(99)) < sender_idle_pct)
        begin
            gap = $urandom_range(1, 6);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {cls, clu};
        s_tlast  <= is_last;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tally_sample(clu, cls, is_last);
    endtask

    // stop offering samples
    task automatic end_burst();
        @(negedge clk);
        s_tvalid <= 1'b0;
    endtask

    // wait until every result is in and the block has finished its scan
    task automatic drain_results();
        end_burst();
        while (expected_purity.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // one register write
    task automatic write_reg(input logic [cpm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [cpm_pkg::CFG_W-1:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        if (idx == cpm_pkg::CFG_IDX_NUM_CLUSTERS)
            shadow_clusters = value;
        else
            shadow_classes = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic configure(input logic [cpm_pkg::CFG_W-1:0] clusters,
                             input logic [cpm_pkg::CFG_W-1:0] classes);
        drain_results();
        write_reg(cpm_pkg::CFG_IDX_NUM_CLUSTERS, clusters);
        write_reg(cpm_pkg::CFG_IDX_NUM_CLASSES, classes);
    endtask

    // mostly legal sizes, sometimes zero or above the maximum
    function automatic logic [cpm_pkg::CFG_W-1:0] pick_reg_value();
        int sel;
        sel = $urandom_range(99);
        if (sel < 70)
            return cpm_pkg::CFG_W'($urandom_range(1, 16));
        else if (sel < 78)
            return '0;
        else if (sel < 88)
            return cpm_pkg::CFG_W'(16);
        else
            return cpm_pkg::CFG_W'($urandom_range(17, 31));
    endfunction

    // random sets with random sizes, labels mostly in range
    task automatic run_random_sets(input int n_items);
        int         sent;
        int         set_len;
        int         clu_lim;
        int         cls_lim;
        logic [7:0] clu;
        logic [7:0] cls;
        sent = 0;
        while (sent < n_items)
        begin
            if ($urandom_range(5) == 0)
                configure(pick_reg_value(), pick_reg_value());
            set_len = ($urandom_range(9) == 0) ? $urandom_range(25, 120) : $urandom_range(1, 24);
            for (int i = 0; i < set_len; i++)
            begin
                // occasional register change inside an open set
                if (i > 0 && $urandom_range(59) == 0)
                begin
                    drain_results();
                    write_reg(cpm_pkg::CFG_IDX_W'($urandom_range(1)), pick_reg_value());
                end
                clu_lim = in_use(shadow_clusters, TB_MAX_CLUSTERS);
                cls_lim = in_use(shadow_classes, TB_MAX_CLASSES);
                if (clu_lim > 0 && $urandom_range(9) < 8)
                    clu = 8'($urandom_range(clu_lim - 1));
                else
                    clu = 8'($urandom_range(255));
                if (cls_lim > 0 && $urandom_range(9) < 9)
                begin
                    if ($urandom_range(1) == 1)
                        cls = 8'(int'(clu) % cls_lim);
                    else
                        cls = 8'($urandom_range(cls_lim - 1));
                end
                else
                    cls = 8'($urandom_range(255));
                send_sample(clu, cls, i == set_len - 1);
                sent++;
            end
        end
    endtask

    task automatic test_default_registers();
        send_sample(8'd0, 8'd0, 1'b0);
        send_sample(8'd15, 8'd15, 1'b0);
        send_sample(8'd255, 8'd255, 1'b0);
        send_sample(8'd3, 8'd200, 1'b0);
        send_sample(8'd15, 8'd15, 1'b0);
        send_sample(8'd7, 8'd7, 1'b1);
    endtask

    // only sample rejected, so nothing is counted
    task automatic test_empty_set();
        send_sample(8'd0, 8'd16, 1'b1);
    endtask

    task automatic test_register_extremes();
        configure(5'd31, 5'd0);
        send_sample(8'd5, 8'd0, 1'b0);
        send_sample(8'd20, 8'd1, 1'b0);
        send_sample(8'd15, 8'd255, 1'b1);
        configure(5'd0, 5'd31);
        send_sample(8'd0, 8'd0, 1'b0);
        send_sample(8'd128, 8'd3, 1'b0);
        send_sample(8'd255, 8'd255, 1'b1);
        configure(5'd1, 5'd1);
        send_sample(8'd0, 8'd0, 1'b0);
        send_sample(8'd0, 8'd1, 1'b0);
        send_sample(8'd1, 8'd0, 1'b0);
        send_sample(8'd0, 8'd0, 1'b1);
    endtask

    // fewer clusters at the final scan than while counting
    task automatic test_mid_set_change();
        configure(5'd16, 5'd16);
        send_sample(8'd10, 8'd2, 1'b0);
        send_sample(8'd10, 8'd2, 1'b0);
        send_sample(8'd3, 8'd1, 1'b0);
        drain_results();
        write_reg(cpm_pkg::CFG_IDX_NUM_CLUSTERS, 5'd4);
        send_sample(8'd1, 8'd1, 1'b1);
    endtask

    task automatic test_full_purity();
        configure(5'd17, 5'd16);
        send_sample(8'd2, 8'd5, 1'b0);
        send_sample(8'd2, 8'd5, 1'b0);
        send_sample(8'd2, 8'd5, 1'b1);
    endtask

    task automatic test_random_traffic();
        sender_idle_pct = 30;
        sink_idle_pct   = 50;
        run_random_sets(PHASE_ITEMS);
        sender_idle_pct = 50;
        sink_idle_pct   = 30;
        run_random_sets(PHASE_ITEMS);
        // no idling, with one long receiver hold-off at the start
        sender_idle_pct = 0;
        sink_idle_pct   = 0;
        configure(5'd16, 5'd16);
        hold_request = 1'b1;
        // short sets back to back so results pile up and the input stalls
        for (int s = 0; s < 4; s++)
        begin
            send_sample(8'(s), 8'(s), 1'b0);
            send_sample(8'(s), 8'd0, 1'b1);
        end
        run_random_sets(PHASE_ITEMS);
    endtask

    // receiver side: random backpressure or a long hold-off
    initial
    begin : sink_driver
        int held;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES)
                begin
                    @(negedge clk);
                    held++;
                end
                hold_request = 1'b0;
            end
            else
                m_tready <= (int'($urandom_range(99)) >= sink_idle_pct);
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge clk)
    begin : result_check
        purity_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_purity.size() == 0)
            begin
                $error("result with no expectation: tdata %h tuser %b", m_tdata, m_tuser);
                mismatch_count++;
            end
            else
            begin
                want = expected_purity.pop_front();
                if (m_tdata[16:0] !== want.purity)
                begin
                    $error("purity: expected %0d, actual %0d", want.purity, m_tdata[16:0]);
                    mismatch_count++;
                end
                if (m_tdata[32:17] !== want.max_sum)
                begin
                    $error("max_sum: expected %0d, actual %0d", want.max_sum, m_tdata[32:17]);
                    mismatch_count++;
                end
                if (m_tdata[48:33] !== want.total_items)
                begin
                    $error("total_items: expected %0d, actual %0d",
                           want.total_items, m_tdata[48:33]);
                    mismatch_count++;
                end
                if (m_tuser !== want.label_error)
                begin
                    $error("label_error: expected %0d, actual %0d", want.label_error, m_tuser);
                    mismatch_count++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        rst_n           = 1'b0;
        s_tvalid        = 1'b0;
        s_tdata         = '0;
        s_tlast         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        cycle_count     = 0;
        mismatch_count  = 0;
        hold_request    = 1'b0;
        sender_idle_pct = 30;
        sink_idle_pct   = 50;
        shadow_clusters = cpm_pkg::CFG_RESET;
        shadow_classes  = cpm_pkg::CFG_RESET;
        set_total       = '0;
        set_error       = 1'b0;
        for (int c = 0; c < TB_MAX_CLUSTERS; c++)
            for (int k = 0; k < TB_MAX_CLASSES; k++)
                class_tally[c][k] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_registers();
        test_empty_set();
        test_register_extremes();
        test_mid_set_change();
        test_full_purity();
        test_random_traffic();

        drain_results();
        if (mismatch_count == 0)
            $display("[cluster_purity_metric_top] OK");
        else
            $display("[cluster_purity_metric_top] ERROR");
        $finish;
    end

endmodule

// ===== cluster_purity_metric_top.f =====
+incdir+rtl
rtl/cpm_pkg.sv
rtl/cpm_count_mem.sv
rtl/cpm_sub_unit.sv
rtl/cluster_purity_metric_top.sv
tb/sv/cluster_purity_metric_top_tb.sv
